### hdl/bed_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the backslash escape decoder.
package bed_pkg;

    localparam int POS_BITS   = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;

    localparam logic [1:0] MODE_STRICT  = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_IGNORE  = 2'd2;

    // Everything one source byte produces: up to two data bytes and an optional status.
    typedef struct packed {
        logic [1:0]  n_data;
        logic        has_status;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic        failed;
        logic        invalid;
        logic [31:0] inv_pos;
    } bundle_t;

endpackage

### hdl/bed_front.sv
`timescale 1ns / 1ps
// Front end: escape parser that turns each accepted source byte into a result bundle.
module bed_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             is_last,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_data,
    output logic             enq,
    output bed_pkg::bundle_t bundle
);

    typedef enum logic [2:0] {
        P_NORMAL = 3'd0,
        P_ESC    = 3'd1,
        P_OCT1   = 3'd2,
        P_OCT2   = 3'd3,
        P_HEX0   = 3'd4,
        P_HEX1   = 3'd5,
        P_DEAD   = 3'd6
    } phase_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    phase_t          phase_reg, phase_next;
    logic [8:0]      pend_reg, pend_next;
    bed_pkg::pos_t   pos_reg, pos_next;
    logic            fail_reg, fail_next;
    logic            inv_reg, inv_next;
    bed_pkg::pos_t   off_reg, off_next;
    logic [1:0]      mode_reg, mode_next;

    logic            pre_v, plain_v, end_v;
    logic [7:0]      pre_b, plain_b, end_b;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    always_comb
    begin
        logic       do_plain;
        logic       bad;
        logic [4:0] hx;
        logic [8:0] v;
        bed_pkg::pos_t cur;
        phase_t     ph;

        do_plain   = 1'b0;
        bad        = 1'b0;
        hx         = hex_decode(in_byte);
        v          = {pend_reg[5:0], in_byte[2:0]};
        cur        = pos_reg;
        ph         = phase_reg;
        pend_next  = pend_reg;
        fail_next  = fail_reg;
        inv_next   = inv_reg;
        off_next   = off_reg;
        pre_v      = 1'b0;
        pre_b      = CH_BSLASH;
        plain_v    = 1'b0;
        plain_b    = in_byte;
        end_v      = 1'b0;
        end_b      = pend_reg[7:0];

        case (phase_reg)
            P_ESC:
            begin
                ph    = P_NORMAL;
                pre_v = 1'b1;
                case (in_byte)
                    8'h0A: pre_v = 1'b0;
                    8'h5C: pre_b = CH_BSLASH;
                    8'h27: pre_b = 8'h27;
                    8'h22: pre_b = 8'h22;
                    8'h62: pre_b = 8'd8;
                    8'h66: pre_b = 8'd12;
                    8'h74: pre_b = 8'd9;
                    8'h6E: pre_b = 8'd10;
                    8'h72: pre_b = 8'd13;
                    8'h76: pre_b = 8'd11;
                    8'h61: pre_b = 8'd7;
                    8'h78:
                    begin
                        pre_v = 1'b0;
                        ph    = P_HEX0;
                    end
                    default:
                    begin
                        if (in_byte >= 8'h30 && in_byte <= 8'h37)
                        begin
                            pre_v     = 1'b0;
                            pend_next = {6'd0, in_byte[2:0]};
                            ph        = P_OCT1;
                        end
                        else
                        begin
                            if (!inv_next)
                            begin
                                inv_next = 1'b1;
                                off_next = cur;
                            end
                            pre_b    = CH_BSLASH;
                            do_plain = 1'b1;
                        end
                    end
                endcase
            end
            P_OCT1, P_OCT2:
            begin
                if (in_byte >= 8'h30 && in_byte <= 8'h37)
                begin
                    if (phase_reg == P_OCT1)
                    begin
                        pend_next = v;
                        ph        = P_OCT2;
                    end
                    else
                    begin
                        if (v[8] && !inv_next)
                        begin
                            inv_next = 1'b1;
                            off_next = cur - bed_pkg::pos_t'(2);
                        end
                        pre_v     = 1'b1;
                        pre_b     = v[7:0];
                        pend_next = 9'd0;
                        ph        = P_NORMAL;
                    end
                end
                else
                begin
                    pre_v     = 1'b1;
                    pre_b     = pend_reg[7:0];
                    pend_next = 9'd0;
                    ph        = P_NORMAL;
                    do_plain  = 1'b1;
                end
            end
            P_HEX0, P_HEX1:
            begin
                if (hx[4] && phase_reg == P_HEX0)
                begin
                    pend_next = {5'd0, hx[3:0]};
                    ph        = P_HEX1;
                end
                else if (hx[4])
                begin
                    pre_v     = 1'b1;
                    pre_b     = {pend_reg[3:0], hx[3:0]};
                    pend_next = 9'd0;
                    ph        = P_NORMAL;
                end
                else
                begin
                    pend_next = 9'd0;
                    ph        = P_NORMAL;
                    bad       = 1'b1;
                end
            end
            P_DEAD:
            begin
                ph = P_DEAD;
            end
            default:
            begin
                ph       = P_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        if (bad)
        begin
            if (mode_reg == bed_pkg::MODE_REPLACE)
            begin
                pre_v    = 1'b1;
                pre_b    = CH_QMARK;
                do_plain = 1'b1;
            end
            else if (mode_reg == bed_pkg::MODE_IGNORE)
            begin
                do_plain = 1'b1;
            end
            else
            begin
                fail_next = 1'b1;
                ph        = P_DEAD;
            end
        end

        if (do_plain)
        begin
            if (in_byte == CH_BSLASH)
            begin
                ph = P_ESC;
            end
            else
            begin
                plain_v = 1'b1;
            end
        end

        pos_next = cur + bed_pkg::pos_t'(1);

        if (is_last)
        begin
            case (ph)
                P_ESC:
                begin
                    fail_next = 1'b1;
                end
                P_OCT1, P_OCT2:
                begin
                    end_v = 1'b1;
                    end_b = pend_next[7:0];
                end
                P_HEX0, P_HEX1:
                begin
                    if (mode_reg == bed_pkg::MODE_REPLACE)
                    begin
                        end_v = 1'b1;
                        end_b = CH_QMARK;
                    end
                    else if (mode_reg != bed_pkg::MODE_IGNORE)
                    begin
                        fail_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        phase_next = ph;

        bundle.n_data     = 2'(pre_v) + 2'(plain_v) + 2'(end_v);
        bundle.has_status = is_last;
        bundle.data0      = pre_v ? pre_b : (plain_v ? plain_b : end_b);
        bundle.data1      = (pre_v && plain_v) ? plain_b : end_b;
        bundle.failed     = fail_next;
        bundle.invalid    = inv_next;
        bundle.inv_pos    = inv_next ? 32'(off_next) : 32'd0;
        enq               = accept && (pre_v || plain_v || end_v || is_last);

        if (is_last)
        begin
            phase_next = P_NORMAL;
            pend_next  = 9'd0;
            pos_next   = '0;
            fail_next  = 1'b0;
            inv_next   = 1'b0;
            off_next   = '0;
        end
    end

    always_comb
    begin
        mode_next = cfg_write ? cfg_data : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_NORMAL;
            pend_reg  <= 9'd0;
            pos_reg   <= '0;
            fail_reg  <= 1'b0;
            inv_reg   <= 1'b0;
            off_reg   <= '0;
            mode_reg  <= bed_pkg::MODE_STRICT;
        end
        else
        begin
            mode_reg <= mode_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                pos_reg   <= pos_next;
                fail_reg  <= fail_next;
                inv_reg   <= inv_next;
                off_reg   <= off_next;
            end
        end
    end

endmodule

### hdl/bed_queue.sv
`timescale 1ns / 1ps
// Short bundle queue between the parser and the result serializer.
module bed_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  bed_pkg::bundle_t wr_data,
    input  logic             rd_en,
    output bed_pkg::bundle_t rd_data,
    output logic             full,
    output logic             empty
);

    bed_pkg::bundle_t                     mem [bed_pkg::Q_DEPTH];
    logic [bed_pkg::Q_PTR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bed_pkg::Q_PTR_BITS-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bed_pkg::Q_CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic                                 do_wr, do_rd;

    assign full    = (cnt_reg == bed_pkg::Q_CNT_BITS'(bed_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + bed_pkg::Q_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + bed_pkg::Q_PTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + bed_pkg::Q_CNT_BITS'(do_wr) - bed_pkg::Q_CNT_BITS'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/bed_back.sv
`timescale 1ns / 1ps
// Back end: hands out the results of the oldest bundle one transaction at a time.
module bed_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  bed_pkg::bundle_t head,
    input  logic             q_empty,
    input  logic             pop,
    output logic             q_rd,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             end_of_run,
    output logic             failed,
    output logic             invalid_seen,
    output logic [31:0]      first_invalid_pos
);

    logic [1:0] idx_reg, idx_next;
    logic       is_data;
    logic       last_item;
    logic       take;

    assign is_data   = (idx_reg < head.n_data);
    assign last_item = ((idx_reg + 2'd1) == (head.n_data + 2'(head.has_status)));
    assign take      = pop && !q_empty;
    assign q_rd      = take && last_item;

    always_comb
    begin
        out_byte          = 8'd0;
        byte_valid        = 1'b0;
        end_of_run        = 1'b0;
        failed            = 1'b0;
        invalid_seen      = 1'b0;
        first_invalid_pos = 32'd0;
        if (is_data)
        begin
            out_byte   = (idx_reg == 2'd0) ? head.data0 : head.data1;
            byte_valid = 1'b1;
        end
        else
        begin
            end_of_run        = 1'b1;
            failed            = head.failed;
            invalid_seen      = head.invalid;
            first_invalid_pos = head.inv_pos;
        end

        idx_next = idx_reg;
        if (take)
        begin
            idx_next = last_item ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### hdl/backslash_escape_decoder.sv
`timescale 1ns / 1ps
// Top level of the backslash escape decoder.
//
//   Channel   Handshake              Payload
//   source    push / full            in_byte, is_last
//   result    pop / empty            out_byte, byte_valid, end_of_run, failed,
//                                    invalid_seen, first_invalid_pos
//   config    cfg_valid / cfg_ready  cfg_data (error_mode)
//
// The parser takes one source byte per cycle and writes its results as one bundle
// into a four-entry queue; the serializer delivers one result transaction per cycle
// while popped and not empty. A source byte yields up to three results, so sustained
// input rate is bounded by how fast results are popped. Input stalls only while the
// queue is full. Reset is asynchronous; it clears the parser state, error_mode and the queue.
module backslash_escape_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    input  logic        push,
    output logic        full,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        end_of_run,
    output logic        failed,
    output logic        invalid_seen,
    output logic [31:0] first_invalid_pos,
    output logic        empty,
    input  logic        pop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    bed_pkg::bundle_t wr_bundle;
    bed_pkg::bundle_t head;
    logic             enq;
    logic             q_rd;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    bed_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .enq       (enq),
        .bundle    (wr_bundle)
    );

    bed_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (wr_bundle),
        .rd_en   (q_rd),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    bed_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .q_empty           (empty),
        .pop               (pop),
        .q_rd              (q_rd),
        .out_byte          (out_byte),
        .byte_valid        (byte_valid),
        .end_of_run        (end_of_run),
        .failed            (failed),
        .invalid_seen      (invalid_seen),
        .first_invalid_pos (first_invalid_pos)
    );

endmodule
